>>> hw/rtl/tcpr_pkg.sv
// Shared types, constants and the 6x8 font ROM for the text console renderer.
// No dependencies; used by tcpr_seq and text_console_page_renderer.
`default_nettype none

package tcpr_pkg;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0,
    CMD_CHAR  = 3'd1,
    CMD_END   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_FILL  = 3'd4
  } tcpr_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAW,
    ST_FINISH
  } tcpr_state_e;

  // Result word handed from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic       truncated;
    logic       scrolled;
  } tcpr_res_t;

  localparam logic [7:0] FONT_FIRST    = 8'h20;
  localparam logic [7:0] FONT_LAST     = 8'h7E;
  localparam logic [7:0] FONT_FALLBACK = 8'h3F;
  localparam logic [7:0] BLANK_COLUMN  = 8'h00;
  localparam int         FONT_GLYPHS   = 95;
  localparam int         FONT_COLS     = 6;

  // One word per glyph, column 0 in the top byte.
  localparam logic [0:FONT_GLYPHS-1][47:0] FONT_ROM = '{
    48'h000000000000, 48'h0000006f0000, 48'h000007000700, 48'h00147f147f14,
    48'h00242a7f2a12, 48'h002313086462, 48'h003649562050, 48'h000000070000,
    48'h00001c224100, 48'h000041221c00, 48'h0014083e0814, 48'h0008083e0808,
    48'h000050300000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003e5149453e, 48'h0000427f4000, 48'h004261514946, 48'h002141454b31,
    48'h001814127f10, 48'h002745454539, 48'h003c4a494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291e, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h003e415d494e, 48'h007e0909097e, 48'h007f49494936, 48'h003e41414122,
    48'h007f4141413e, 48'h007f49494941, 48'h007f09090901, 48'h003e4149497a,
    48'h007f0808087f, 48'h0000417f4100, 48'h002040413f01, 48'h007f08142241,
    48'h007f40404040, 48'h007f020c027f, 48'h007f0408107f, 48'h003e4141413e,
    48'h007f09090906, 48'h003e4151215e, 48'h007f09192946, 48'h004649494931,
    48'h0001017f0101, 48'h003f4040403f, 48'h000f3040300f, 48'h003f4030403f,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h003c4a49291e,
    48'h000204081020, 48'h0000417f0000, 48'h000402010204, 48'h004040404040,
    48'h000000030400, 48'h002054545478, 48'h007f48444438, 48'h003844444420,
    48'h00384444487f, 48'h003854545418, 48'h00087e090102, 48'h000c5252523e,
    48'h007f08040478, 48'h0000447d4000, 48'h002040443d00, 48'h00007f102844,
    48'h0000417f4000, 48'h007c04180478, 48'h007c08040478, 48'h003844444438,
    48'h007c14141408, 48'h00081414187c, 48'h007c08040408, 48'h004854545420,
    48'h00043f444020, 48'h003c4040207c, 48'h001c2040201c, 48'h003c4030403c,
    48'h004428102844, 48'h000c5050503c, 48'h004464544c44, 48'h000008364141,
    48'h0000007f0000, 48'h004141360800, 48'h000402040804
  };

  // Glyph column byte; columns past the ROM width are blank.
  function automatic logic [7:0] font_byte(input logic [6:0] glyph, input logic [2:0] col);
    logic [47:0] word;
    int          sel;
    word = '0;
    sel  = 0;
    if ((int'(glyph) < FONT_GLYPHS) && (int'(col) < FONT_COLS)) begin
      word = FONT_ROM[glyph];
      sel  = 8 * (FONT_COLS - 1 - int'(col));
      return word[sel +: 8];
    end
    return BLANK_COLUMN;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcpr_frame_mem.sv
// Frame store: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module tcpr_frame_mem #(
  parameter int DEPTH = 1056,
  parameter int AW    = 11
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/tcpr_seq.sv
// Command sequencer: cursor/line state, glyph drawing, scroll copy and fill sweeps
// over the frame store. Depends on tcpr_pkg.
`default_nettype none

module tcpr_seq #(
  parameter int COLUMNS     = 132,
  parameter int PAGES       = 8,
  parameter int GLYPH_WIDTH = 6,
  parameter int AW          = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               new_line_i,
  input  wire logic [2:0]         page_index_i,
  input  wire logic [7:0]         column_index_i,
  input  wire logic [7:0]         fill_value_i,
  output      tcpr_pkg::tcpr_res_t res_o,
  input  wire logic               res_ready_i,
  output      logic               mem_we_o,
  output      logic [AW-1:0]      mem_waddr_o,
  output      logic [7:0]         mem_wdata_o,
  output      logic               mem_re_o,
  output      logic [AW-1:0]      mem_raddr_o,
  input  wire logic [7:0]         mem_rdata_i
);

  import tcpr_pkg::*;

  localparam int TOTAL  = PAGES * COLUMNS;
  localparam int COPY_N = (PAGES - 1) * COLUMNS;
  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int TW     = $clog2(PAGES + 1);
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int GCW    = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A = AW'(TOTAL - 1);
  localparam logic [AW-1:0] COPY_A = AW'(COPY_N);

  tcpr_state_e state_q, state_d;

  logic [TW-1:0]  text_line_q;
  logic [CW-1:0]  cursor_q;
  logic [PW-1:0]  wpage_q;
  logic           line_full_q;
  logic [6:0]     glyph_q;
  logic [GCW-1:0] gcol_q;
  logic [AW-1:0]  cnt_q;
  logic [7:0]     fill_q;
  logic           sweep_reply_q;
  logic           wp_valid_q;
  logic [AW-1:0]  wp_addr_q;
  logic           wp_copy_q;
  logic           res_rd_q;
  logic           res_trunc_q;
  logic           res_scr_q;

  logic           accept;
  logic           at_last;
  logic           col_fits;
  logic           lines_used;
  logic           rd_in_range;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  draw_addr;
  logic [6:0]     glyph_sel;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign at_last     = (cnt_q == LAST_A);
  assign col_fits    = (cursor_q < CW'(COLUMNS));
  assign lines_used  = (text_line_q == TW'(PAGES));
  assign rd_in_range = (int'(page_index_i) < PAGES) && (int'(column_index_i) < COLUMNS);
  assign rd_addr     = AW'(page_index_i) * COLS_A + AW'(column_index_i);
  assign draw_addr   = AW'(wpage_q) * COLS_A + AW'(cursor_q);
  assign glyph_sel   = ((char_code_i < FONT_FIRST) || (char_code_i > FONT_LAST))
                     ? 7'(FONT_FALLBACK - FONT_FIRST) : 7'(char_code_i - FONT_FIRST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_BEGIN: state_d = lines_used ? ST_SCROLL : ST_FINISH;
            CMD_CHAR:  state_d = line_full_q ? ST_FINISH : ST_DRAW;
            CMD_FILL:  state_d = ST_CLEAR;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        if (at_last) begin
          state_d = sweep_reply_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (at_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_DRAW: begin
        if (!col_fits || (gcol_q == GCW'(GLYPH_WIDTH - 1))) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port and result
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = draw_addr;
    mem_wdata_o = font_byte(glyph_q, 3'(gcol_q));
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr;
    // scroll writes follow their reads in the next cycle
    if (wp_valid_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wp_addr_q;
      mem_wdata_o = wp_copy_q ? mem_rdata_i : BLANK_COLUMN;
    end else if (state_q == ST_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = cnt_q;
      mem_wdata_o = sweep_reply_q ? fill_q : BLANK_COLUMN;
    end else if (state_q == ST_DRAW) begin
      mem_we_o = col_fits;
    end
    if (state_q == ST_SCROLL) begin
      mem_re_o    = (cnt_q < COPY_A);
      mem_raddr_o = cnt_q + COLS_A;
    end else if (accept && (command_i == CMD_READ)) begin
      mem_re_o = rd_in_range;
    end

    res_o.valid     = (state_q == ST_FINISH);
    res_o.read_data = res_rd_q ? mem_rdata_i : 8'h00;
    res_o.truncated = res_trunc_q;
    res_o.scrolled  = res_scr_q;
    in_stall_o      = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_line_q   <= '0;
      cursor_q      <= '0;
      wpage_q       <= '0;
      line_full_q   <= 1'b0;
      glyph_q       <= '0;
      gcol_q        <= '0;
      cnt_q         <= '0;
      fill_q        <= '0;
      sweep_reply_q <= 1'b0;
      wp_valid_q    <= 1'b0;
      wp_addr_q     <= '0;
      wp_copy_q     <= 1'b0;
      res_rd_q      <= 1'b0;
      res_trunc_q   <= 1'b0;
      res_scr_q     <= 1'b0;
    end else begin
      wp_valid_q <= (state_q == ST_SCROLL);
      wp_addr_q  <= cnt_q;
      wp_copy_q  <= (cnt_q < COPY_A);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            res_rd_q    <= (command_i == CMD_READ) && rd_in_range;
            res_trunc_q <= (command_i == CMD_CHAR) && line_full_q;
            res_scr_q   <= (command_i == CMD_BEGIN) && lines_used;
            cnt_q       <= '0;
            case (command_i)
              CMD_BEGIN: begin
                line_full_q <= 1'b0;
                if (lines_used) begin
                  wpage_q <= PW'(PAGES - 1);
                end else begin
                  wpage_q <= text_line_q[PW-1:0];
                end
              end
              CMD_CHAR: begin
                glyph_q <= glyph_sel;
                gcol_q  <= '0;
              end
              CMD_END: begin
                if (new_line_i) begin
                  if (!lines_used) begin
                    text_line_q <= text_line_q + TW'(1);
                  end
                  cursor_q <= '0;
                end
              end
              CMD_FILL: begin
                fill_q        <= fill_value_i;
                sweep_reply_q <= 1'b1;
                text_line_q   <= '0;
                cursor_q      <= '0;
                wpage_q       <= '0;
                line_full_q   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR, ST_SCROLL: cnt_q <= cnt_q + AW'(1);
        ST_DRAW: begin
          if (col_fits) begin
            cursor_q <= cursor_q + CW'(1);
            gcol_q   <= gcol_q + GCW'(1);
          end else begin
            line_full_q <= 1'b1;
            res_trunc_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_page_renderer.sv
// Text console page renderer top level: sequencer, frame store RAM and the
// result register. Depends on tcpr_pkg, tcpr_seq, tcpr_frame_mem.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o  command, char_code, new_line,
//                                              page_index, column_index, fill_value
//   out      output     out_valid_o/out_stall_i read_data, truncated, scrolled
//
// One item at a time. Character: one frame store write per glyph column that fits;
// read, end and non-scrolling begin string: no sweep; fill and scroll: a sweep
// of all PAGES*COLUMNS bytes (one byte per cycle through the single write port).
// After reset a clearing pass over all PAGES*COLUMNS bytes runs with in_stall_o high.
// A waiting result sits in the output register; the next word is taken meanwhile.
`default_nettype none

module text_console_page_renderer #(
  parameter int COLUMNS     = 132,
  parameter int PAGES       = 8,
  parameter int GLYPH_WIDTH = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [2:0] command_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       new_line_i,
  input  wire logic [2:0] page_index_i,
  input  wire logic [7:0] column_index_i,
  input  wire logic [7:0] fill_value_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] read_data_o,
  output      logic       truncated_o,
  output      logic       scrolled_o
);

  import tcpr_pkg::*;

  localparam int TOTAL = PAGES * COLUMNS;
  localparam int AW    = $clog2(TOTAL);

  tcpr_res_t     res;
  logic          res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    read_data_q;
  logic          truncated_q;
  logic          scrolled_q;

  tcpr_seq #(
    .COLUMNS    (COLUMNS),
    .PAGES      (PAGES),
    .GLYPH_WIDTH(GLYPH_WIDTH),
    .AW         (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .char_code_i   (char_code_i),
    .new_line_i    (new_line_i),
    .page_index_i  (page_index_i),
    .column_index_i(column_index_i),
    .fill_value_i  (fill_value_i),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  tcpr_frame_mem #(
    .DEPTH(TOTAL),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register frees when empty or taken this cycle
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res.valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      read_data_q <= res.read_data;
      truncated_q <= res.truncated;
      scrolled_q  <= res.scrolled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign truncated_o = truncated_q;
  assign scrolled_o  = scrolled_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not start work");

  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res.valid)
    else $error("result raised while sequencer idle");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(truncated_o && scrolled_o))
    else $error("truncated and scrolled both set");

  a_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (truncated_o || scrolled_o) |-> read_data_o == 8'h00)
    else $error("read data nonzero on non-read word");

endmodule

`default_nettype wire
